@@ rtl/spc_pkg.sv @@
// Shared types and constants for the sensor compensation block.
package spc_pkg;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 64;
	localparam int unsigned HUM_W = 17;
	localparam int unsigned QUEUE_DEPTH = 2;

	// Pipeline landmarks of the back end.
	localparam int unsigned STG_SIDE = 4;
	localparam int unsigned STG_HUM = 10;
	localparam int unsigned STG_INV = 12;
	localparam int unsigned DIV_STEPS = 64;
	localparam int unsigned STG_LAST = 82;
	localparam int unsigned STG_OUT = 83;

	localparam logic [31:0] FINE_HUM_ZERO = 32'd76800;
	localparam logic [31:0] HUM_MAX = 32'd419430400;
	localparam logic [63:0] FINE_P_OFFSET = 64'd128000;
	localparam logic [63:0] P_RAW_BASE = 64'd1048576;
	localparam logic [63:0] P_SCALE = 64'd3125;
	localparam logic [31:0] HUM_C_BIAS = 32'd2097152;
	localparam logic [31:0] HUM_X_ROUND = 32'd16384;
	localparam logic [31:0] HUM_B_BIAS = 32'd32768;
	localparam logic [31:0] HUM_Y_ROUND = 32'd8192;
	localparam logic [31:0] TEMP_ROUND = 32'd128;
	localparam logic [63:0] P_E1_BIAS = 64'h0000_8000_0000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEMP = 3'd0,
		REG_PRESS_A = 3'd1,
		REG_PRESS_B = 3'd2,
		REG_PRESS_C = 3'd3,
		REG_HUM_A = 3'd4,
		REG_HUM_B = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		logic [15:0] p1;
		logic [15:0] p2;
		logic [15:0] p3;
		logic [15:0] p4;
		logic [15:0] p5;
		logic [15:0] p6;
		logic [15:0] p7;
		logic [15:0] p8;
		logic [15:0] p9;
		logic [7:0] h1;
		logic [15:0] h2;
		logic [7:0] h3;
		logic [15:0] h4;
		logic [15:0] h5;
		logic [7:0] h6;
	} calib_t;

	typedef struct packed {
		logic [19:0] raw_t;
		logic [19:0] raw_p;
		logic [15:0] raw_h;
	} item_t;

	typedef struct packed {
		logic [31:0] tc;
		logic [31:0] fine;
		logic [HUM_W-1:0] hum;
	} side_t;

	typedef struct packed {
		logic [63:0] rem;
		logic [63:0] dq;
		logic [63:0] mb;
		logic neg;
	} div_t;

	typedef struct packed {
		logic [31:0] tc;
		logic [31:0] fine;
		logic [31:0] pres;
		logic inval;
		logic [HUM_W-1:0] hum;
	} res_t;

endpackage

@@ rtl/spc_front.sv @@
// Configuration registers and calibration word unpacking.
module spc_front (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [spc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [spc_pkg::CFG_DATA_W-1:0] cfg_data,
	output spc_pkg::calib_t calib
);

	logic [47:0] temp_q;
	logic [63:0] press_a_q;
	logic [63:0] press_b_q;
	logic [15:0] press_c_q;
	logic [31:0] hum_a_q;
	logic [39:0] hum_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q <= '0;
			press_a_q <= '0;
			press_b_q <= '0;
			press_c_q <= '0;
			hum_a_q <= '0;
			hum_b_q <= '0;
		end else if (cfg_we) begin
			unique case (spc_pkg::cfg_idx_t'(cfg_index))
				spc_pkg::REG_TEMP: temp_q <= cfg_data[47:0];
				spc_pkg::REG_PRESS_A: press_a_q <= cfg_data;
				spc_pkg::REG_PRESS_B: press_b_q <= cfg_data;
				spc_pkg::REG_PRESS_C: press_c_q <= cfg_data[15:0];
				spc_pkg::REG_HUM_A: hum_a_q <= cfg_data[31:0];
				spc_pkg::REG_HUM_B: hum_b_q <= cfg_data[39:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		calib.t1 = temp_q[15:0];
		calib.t2 = temp_q[31:16];
		calib.t3 = temp_q[47:32];
		calib.p1 = press_a_q[15:0];
		calib.p2 = press_a_q[31:16];
		calib.p3 = press_a_q[47:32];
		calib.p4 = press_a_q[63:48];
		calib.p5 = press_b_q[15:0];
		calib.p6 = press_b_q[31:16];
		calib.p7 = press_b_q[47:32];
		calib.p8 = press_b_q[63:48];
		calib.p9 = press_c_q;
		calib.h1 = hum_a_q[7:0];
		calib.h2 = hum_a_q[23:8];
		calib.h3 = hum_a_q[31:24];
		calib.h4 = hum_b_q[15:0];
		calib.h5 = hum_b_q[31:16];
		calib.h6 = hum_b_q[39:32];
	end

endmodule

@@ rtl/spc_queue.sv @@
// Two-entry beat queue between input channel and datapath.
module spc_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  spc_pkg::item_t in_item,
	output logic out_valid,
	input  logic out_ready,
	output spc_pkg::item_t out_item
);

	spc_pkg::item_t mem_q [spc_pkg::QUEUE_DEPTH];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;
	logic push;
	logic pop;

	assign in_ready = (cnt_q != 2'(spc_pkg::QUEUE_DEPTH));
	assign out_valid = (cnt_q != 2'd0);
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;
	assign out_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

@@ rtl/spc_mul64.sv @@
// Two-stage 64x64 multiplier keeping the low 64 product bits.
module spc_mul64 (
	input  logic clk,
	input  logic en,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] p
);

	logic [63:0] pp0_s1;
	logic [31:0] pp1_s1;
	logic [31:0] pp2_s1;
	logic [63:0] a_lo;
	logic [63:0] b_lo;
	logic [31:0] cross_s1;

	assign a_lo = {32'd0, a[31:0]};
	assign b_lo = {32'd0, b[31:0]};
	assign cross_s1 = pp1_s1 + pp2_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			pp0_s1 <= a_lo * b_lo;
			pp1_s1 <= a[31:0] * b[63:32];
			pp2_s1 <= a[63:32] * b[31:0];
			p <= pp0_s1 + {cross_s1, 32'd0};
		end
	end

endmodule

@@ rtl/spc_back.sv @@
// Compensation datapath: temperature, humidity and pressure pipeline.
module spc_back (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  spc_pkg::item_t in_item,
	input  spc_pkg::calib_t calib,
	output logic out_valid,
	input  logic out_ready,
	output spc_pkg::res_t out_res
);

	localparam int unsigned SL = spc_pkg::STG_LAST;

	logic en;
	logic [spc_pkg::STG_OUT:1] vld_q;

	// sign- or zero-extended calibration
	logic [31:0] t1x, t2x, t3x;
	logic [31:0] h1x, h2x, h3x, h4x, h5x, h6x;
	logic [63:0] p1x, p2x, p3x, p4x, p5x, p6x, p7x, p8x, p9x;

	assign t1x = {16'd0, calib.t1};
	assign t2x = {{16{calib.t2[15]}}, calib.t2};
	assign t3x = {{16{calib.t3[15]}}, calib.t3};
	assign h1x = {24'd0, calib.h1};
	assign h2x = {{16{calib.h2[15]}}, calib.h2};
	assign h3x = {24'd0, calib.h3};
	assign h4x = {{16{calib.h4[15]}}, calib.h4};
	assign h5x = {{16{calib.h5[15]}}, calib.h5};
	assign h6x = {{24{calib.h6[7]}}, calib.h6};
	assign p1x = {48'd0, calib.p1};
	assign p2x = {{48{calib.p2[15]}}, calib.p2};
	assign p3x = {{48{calib.p3[15]}}, calib.p3};
	assign p4x = {{48{calib.p4[15]}}, calib.p4};
	assign p5x = {{48{calib.p5[15]}}, calib.p5};
	assign p6x = {{48{calib.p6[15]}}, calib.p6};
	assign p7x = {{48{calib.p7[15]}}, calib.p7};
	assign p8x = {{48{calib.p8[15]}}, calib.p8};
	assign p9x = {{48{calib.p9[15]}}, calib.p9};

	assign en = !vld_q[spc_pkg::STG_OUT] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[spc_pkg::STG_OUT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[spc_pkg::STG_OUT-1:1], in_valid};
		end
	end

	// temperature
	logic [31:0] d1, d2;
	logic [31:0] m1_s1, m2_s1;
	logic [31:0] m2_sh;
	logic [31:0] v1_s2, m3_s2;
	logic [31:0] v1_n, m3_sh;
	logic [31:0] fine_s3;
	logic [19:0] ap_q [1:9];
	logic [15:0] ah_q [1:4];

	assign d1 = {15'd0, in_item.raw_t[19:3]} - {15'd0, calib.t1, 1'b0};
	assign d2 = {16'd0, in_item.raw_t[19:4]} - t1x;
	assign m2_sh = $signed(m2_s1) >>> 12;
	assign v1_n = $signed(m1_s1) >>> 11;
	assign m3_sh = $signed(m3_s2) >>> 14;

	always_ff @(posedge clk) begin
		if (en) begin
			m1_s1 <= d1 * t2x;
			m2_s1 <= d2 * d2;
			ap_q[1] <= in_item.raw_p;
			ah_q[1] <= in_item.raw_h;
			for (int i = 2; i <= 9; i++) ap_q[i] <= ap_q[i-1];
			for (int i = 2; i <= 4; i++) ah_q[i] <= ah_q[i-1];
			v1_s2 <= v1_n;
			m3_s2 <= m2_sh * t3x;
			fine_s3 <= v1_s2 + m3_sh;
		end
	end

	// humidity
	logic [31:0] tc_n, v_n;
	logic [31:0] v_s4, hxm_s4, am_s4, bm_s4;
	logic [63:0] e1_s4;
	logic [31:0] x_n, a_n, b_n;
	logic [31:0] x_q [5:6];
	logic vz_q [5:9];
	logic [31:0] ab_s5;
	logic [31:0] c_n, ch_s6;
	logic [31:0] y_n, r_s7;
	logic [31:0] s_n, ss_s8, r_s8;
	logic [31:0] ss_sh, sh_s9, r_s9;
	logic [31:0] rr, sh_sh;
	logic [spc_pkg::HUM_W-1:0] hum_n;
	spc_pkg::side_t side_q [spc_pkg::STG_SIDE:SL];
	spc_pkg::side_t side_new;

	assign tc_n = $signed(fine_s3 * 32'd5 + spc_pkg::TEMP_ROUND) >>> 8;
	assign v_n = fine_s3 - spc_pkg::FINE_HUM_ZERO;
	assign x_n = $signed({2'd0, ah_q[4], 14'd0} - {h4x[11:0], 20'd0} - hxm_s4
		+ spc_pkg::HUM_X_ROUND) >>> 15;
	assign a_n = $signed(am_s4) >>> 10;
	assign b_n = $unsigned($signed(bm_s4) >>> 11) + spc_pkg::HUM_B_BIAS;
	assign c_n = $unsigned($signed(ab_s5) >>> 10) + spc_pkg::HUM_C_BIAS;
	assign y_n = $signed(ch_s6 + spc_pkg::HUM_Y_ROUND) >>> 14;
	assign s_n = $signed(r_s7) >>> 15;
	assign ss_sh = $signed(ss_s8) >>> 7;
	assign sh_sh = $signed(sh_s9) >>> 4;
	assign rr = r_s9 - sh_sh;

	always_comb begin
		if (vz_q[9] || rr[31]) begin
			hum_n = '0;
		end else if (rr > spc_pkg::HUM_MAX) begin
			hum_n = spc_pkg::HUM_MAX[28:12];
		end else begin
			hum_n = rr[28:12];
		end
		side_new = side_q[spc_pkg::STG_HUM-1];
		side_new.hum = hum_n;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s4 <= v_n;
			hxm_s4 <= h5x * v_n;
			am_s4 <= v_n * h6x;
			bm_s4 <= v_n * h3x;
			e1_s4 <= {{32{fine_s3[31]}}, fine_s3} - spc_pkg::FINE_P_OFFSET;
			side_q[spc_pkg::STG_SIDE] <= '{tc: tc_n, fine: fine_s3, hum: '0};
			for (int i = spc_pkg::STG_SIDE + 1; i <= SL; i++) begin
				side_q[i] <= (i == spc_pkg::STG_HUM) ? side_new : side_q[i-1];
			end
			x_q[5] <= x_n;
			x_q[6] <= x_q[5];
			vz_q[5] <= (v_s4 == 32'd0);
			for (int i = 6; i <= 9; i++) vz_q[i] <= vz_q[i-1];
			ab_s5 <= a_n * b_n;
			ch_s6 <= c_n * h2x;
			r_s7 <= x_q[6] * y_n;
			ss_s8 <= s_n * s_n;
			r_s8 <= r_s7;
			sh_s9 <= ss_sh * h1x;
			r_s9 <= r_s8;
		end
	end

	// pressure, compensation terms
	logic [63:0] ee_s6, e1p5_s6, e1p2_s6;
	logic [63:0] e1p5_s7, e1p5_s8, e1p2_s7, e1p2_s8;
	logic [63:0] eep6_s8, eep3_s8;
	logic [63:0] e2_s9, e1b_s9;
	logic [63:0] pp_n, nm_n;
	logic [63:0] num_s11, den_s11;
	logic [63:0] num_s12, den_s12;
	logic [63:0] e1c_n;
	logic inv_q [spc_pkg::STG_INV:SL];

	spc_mul64 u_ee (.clk(clk), .en(en), .a(e1_s4), .b(e1_s4), .p(ee_s6));
	spc_mul64 u_e1p5 (.clk(clk), .en(en), .a(e1_s4), .b(p5x), .p(e1p5_s6));
	spc_mul64 u_e1p2 (.clk(clk), .en(en), .a(e1_s4), .b(p2x), .p(e1p2_s6));
	spc_mul64 u_eep6 (.clk(clk), .en(en), .a(ee_s6), .b(p6x), .p(eep6_s8));
	spc_mul64 u_eep3 (.clk(clk), .en(en), .a(ee_s6), .b(p3x), .p(eep3_s8));

	assign pp_n = spc_pkg::P_RAW_BASE - {44'd0, ap_q[9]};
	assign nm_n = {pp_n[32:0], 31'd0} - e2_s9;

	spc_mul64 u_num (.clk(clk), .en(en), .a(nm_n), .b(spc_pkg::P_SCALE), .p(num_s11));
	spc_mul64 u_den (.clk(clk), .en(en), .a(spc_pkg::P_E1_BIAS + e1b_s9), .b(p1x),
		.p(den_s11));

	assign e1c_n = $signed(den_s11) >>> 33;

	always_ff @(posedge clk) begin
		if (en) begin
			e1p5_s7 <= e1p5_s6;
			e1p5_s8 <= e1p5_s7;
			e1p2_s7 <= e1p2_s6;
			e1p2_s8 <= e1p2_s7;
			e2_s9 <= eep6_s8 + {e1p5_s8[46:0], 17'd0} + {p4x[28:0], 35'd0};
			e1b_s9 <= $unsigned($signed(eep3_s8) >>> 8) + {e1p2_s8[51:0], 12'd0};
			num_s12 <= num_s11;
			den_s12 <= e1c_n;
			inv_q[spc_pkg::STG_INV] <= (e1c_n == 64'd0);
			for (int i = spc_pkg::STG_INV + 1; i <= SL; i++) inv_q[i] <= inv_q[i-1];
		end
	end

	// pressure, restoring divider, one quotient bit per stage
	spc_pkg::div_t div_q [0:spc_pkg::DIV_STEPS];
	spc_pkg::div_t div_d [1:spc_pkg::DIV_STEPS];
	logic [64:0] trial;
	logic [64:0] diff;

	always_comb begin
		trial = '0;
		diff = '0;
		for (int k = 1; k <= spc_pkg::DIV_STEPS; k++) begin
			trial = {div_q[k-1].rem, div_q[k-1].dq[63]};
			diff = trial - {1'b0, div_q[k-1].mb};
			div_d[k] = div_q[k-1];
			if (!diff[64]) begin
				div_d[k].rem = diff[63:0];
				div_d[k].dq = {div_q[k-1].dq[62:0], 1'b1};
			end else begin
				div_d[k].rem = trial[63:0];
				div_d[k].dq = {div_q[k-1].dq[62:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_q[0].rem <= '0;
			div_q[0].dq <= num_s12[63] ? (64'd0 - num_s12) : num_s12;
			div_q[0].mb <= den_s12[63] ? (64'd0 - den_s12) : den_s12;
			div_q[0].neg <= num_s12[63] ^ den_s12[63];
			for (int k = 1; k <= spc_pkg::DIV_STEPS; k++) div_q[k] <= div_d[k];
		end
	end

	// pressure, final terms
	spc_pkg::div_t div_end;
	logic [63:0] p_s78, p_s79, p_s80, p_s81, p_s82;
	logic [63:0] q13_n;
	logic [63:0] qq_s80, p8p_s80, f1r_s82;
	logic [63:0] f2_s81, f2_s82;
	logic [63:0] f1_n, sum_n, pf_n;

	assign div_end = div_q[spc_pkg::DIV_STEPS];
	assign q13_n = $signed(p_s78) >>> 13;

	spc_mul64 u_qq (.clk(clk), .en(en), .a(q13_n), .b(q13_n), .p(qq_s80));
	spc_mul64 u_p8p (.clk(clk), .en(en), .a(p_s78), .b(p8x), .p(p8p_s80));
	spc_mul64 u_qqp9 (.clk(clk), .en(en), .a(qq_s80), .b(p9x), .p(f1r_s82));

	assign f1_n = $signed(f1r_s82) >>> 25;
	assign sum_n = p_s82 + f1_n + f2_s82;
	assign pf_n = $unsigned($signed(sum_n) >>> 8) + {p7x[59:0], 4'd0};

	always_ff @(posedge clk) begin
		if (en) begin
			p_s78 <= div_end.neg ? (64'd0 - div_end.dq) : div_end.dq;
			p_s79 <= p_s78;
			p_s80 <= p_s79;
			p_s81 <= p_s80;
			p_s82 <= p_s81;
			f2_s81 <= $signed(p8p_s80) >>> 19;
			f2_s82 <= f2_s81;
			out_res.tc <= side_q[SL].tc;
			out_res.fine <= side_q[SL].fine;
			out_res.hum <= side_q[SL].hum;
			out_res.inval <= inv_q[SL];
			out_res.pres <= inv_q[SL] ? 32'd0 : pf_n[31:0];
		end
	end

endmodule

@@ rtl/sensor_ptf_compensation_top.sv @@
// Top level of the temperature, pressure and humidity compensation block.
// Each input beat passes through the queue and then the back-end pipeline to its result beat.
// Throughput: one beat per cycle; the 64-stage pipelined pressure divider sets the depth.
// A stalled output holds the whole datapath; the two-entry queue absorbs input beats.
// Reset: arst_n clears calibration registers to zero and empties queue and pipeline.
module sensor_ptf_compensation_top (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [spc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [spc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic [19:0] raw_temperature,
	input  logic [19:0] raw_pressure,
	input  logic [15:0] raw_humidity,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [31:0] temperature_centi,
	output logic signed [31:0] fine_temperature,
	output logic [31:0] pressure_q24_8,
	output logic pressure_invalid,
	output logic [16:0] humidity_q22_10
);

	spc_pkg::calib_t calib;
	spc_pkg::item_t in_item;
	spc_pkg::item_t q_item;
	spc_pkg::res_t res;
	logic q_valid;
	logic q_ready;

	assign in_item = '{raw_t: raw_temperature, raw_p: raw_pressure, raw_h: raw_humidity};

	spc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.calib(calib)
	);

	spc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(q_valid),
		.out_ready(q_ready),
		.out_item(q_item)
	);

	spc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(q_valid),
		.in_ready(q_ready),
		.in_item(q_item),
		.calib(calib),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_res(res)
	);

	assign temperature_centi = res.tc;
	assign fine_temperature = res.fine;
	assign pressure_q24_8 = res.pres;
	assign pressure_invalid = res.inval;
	assign humidity_q22_10 = res.hum;

endmodule

@@ rtl/spc_chk.sv @@
// Port-level checks for the compensation block, bound to the top level.
module spc_chk (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic signed [31:0] temperature_centi,
	input logic signed [31:0] fine_temperature,
	input logic [31:0] pressure_q24_8,
	input logic pressure_invalid,
	input logic [16:0] humidity_q22_10
);

	logic [31:0] tc_chk;

	assign tc_chk = $signed(fine_temperature * 32'd5 + 32'd128) >>> 8;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pressure_q24_8))
		else $error("result beat dropped or changed while stalled");

	a_inval_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pressure_invalid |-> pressure_q24_8 == 32'd0)
		else $error("invalid pressure not forced to zero");

	a_hum_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> humidity_q22_10 <= 17'd102400)
		else $error("humidity above clamp");

	a_temp_fine: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> temperature_centi == tc_chk)
		else $error("temperature does not match fine temperature");

endmodule

bind sensor_ptf_compensation_top spc_chk u_chk (.*);
